// File: rtl/core/zmp_pkg.sv
// Shared widths, constants and register codes for the zone map min/max pruner.
package zmp_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 64;

   // Rows in one zone; counts stop at this or at the field maximum.
   localparam longint unsigned ZONE_ROWS = 64'd65536;
   localparam longint unsigned COUNT_FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
   localparam longint unsigned COUNT_CAP_L =
      (ZONE_ROWS < COUNT_FIELD_MAX) ? ZONE_ROWS : COUNT_FIELD_MAX;
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_CAP_L[COUNT_W-1:0];

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PREDICATE_OP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT_VALUE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT_IS_NULL = 2'd2;

   // Predicate operator codes.
   typedef enum logic [2:0] {
      OP_EQ    = 3'd0,
      OP_NE    = 3'd1,
      OP_LT    = 3'd2,
      OP_LE    = 3'd3,
      OP_GT    = 3'd4,
      OP_GE    = 3'd5,
      OP_OTHER = 3'd6
   } pred_op_type;

endpackage

// File: rtl/core/zmp_req_if.sv
// Input channel: one column value or NULL mark per transaction.
interface zmp_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [zmp_pkg::VALUE_W-1:0] value;
   logic                               is_null;
   logic                               zone_start;

   modport source (output valid, value, is_null, zone_start, input ready);
   modport sink (input valid, value, is_null, zone_start, output ready);
endinterface

// File: rtl/core/zmp_rsp_if.sv
// Result channel: zone map summary and match flag per transaction.
interface zmp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               may_match;
   logic signed [zmp_pkg::VALUE_W-1:0] zone_min;
   logic signed [zmp_pkg::VALUE_W-1:0] zone_max;
   logic [zmp_pkg::COUNT_W-1:0]        value_count;
   logic [zmp_pkg::COUNT_W-1:0]        null_count;
   logic                               has_values;

   modport source (output valid, may_match, zone_min, zone_max, value_count, null_count,
                   has_values, input ready);
   modport sink (input valid, may_match, zone_min, zone_max, value_count, null_count,
                 has_values, output ready);
endinterface

// File: rtl/core/zone_map_min_max_pruner_top.sv
// Zone map min/max pruner: running min, max and row counts with a predicate check.
//
// Each transaction on req_if carries one column value (or a NULL mark) and
// yields exactly one transaction on rsp_if with the zone's minimum, maximum,
// non-NULL and NULL counts and whether the configured predicate may match.
// The block takes one transaction per clock cycle unless rsp_if.ready stalls it;
// a result passes the input register, then the result register, with the zone's
// min/max/count update combinational between them. Configuration through csr_*
// is to be written by the user only while no transaction is in flight; the block
// does not enforce this. Counts saturate at the smaller of zone size and field max.
module zone_map_min_max_pruner_top (
   input  logic                                clock,
   input  logic                                reset,
   zmp_req_if.sink                             req_if,
   zmp_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [zmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [zmp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [2:0]                         pred_op_ff;
   logic signed [zmp_pkg::VALUE_W-1:0] const_value_ff;
   logic                               const_null_ff;

   // Input stage
   logic                               in_valid_ff;
   logic signed [zmp_pkg::VALUE_W-1:0] in_value_ff;
   logic                               in_null_ff;
   logic                               in_start_ff;

   // Zone state
   logic                               have_env_ff, have_env_in;
   logic signed [zmp_pkg::VALUE_W-1:0] min_ff, min_in;
   logic signed [zmp_pkg::VALUE_W-1:0] max_ff, max_in;
   logic [zmp_pkg::COUNT_W-1:0]        rows_val_ff, rows_val_in;
   logic [zmp_pkg::COUNT_W-1:0]        rows_null_ff, rows_null_in;

   // Result stage
   logic                               out_valid_ff;
   logic                               match_ff, match_in;

   logic                               advance;
   logic                               base_env;
   logic signed [zmp_pkg::VALUE_W-1:0] base_min;
   logic signed [zmp_pkg::VALUE_W-1:0] base_max;
   logic [zmp_pkg::COUNT_W-1:0]        base_val;
   logic [zmp_pkg::COUNT_W-1:0]        base_null;
   logic                               op_hit;

   // Move the input stage forward when the result register is free or draining
   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pred_op_ff <= zmp_pkg::OP_OTHER;
         const_value_ff <= '0;
         const_null_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            zmp_pkg::CSR_PREDICATE_OP: pred_op_ff <= csr_wdata[2:0];
            zmp_pkg::CSR_CONSTANT_VALUE: const_value_ff <= csr_wdata;
            zmp_pkg::CSR_CONSTANT_IS_NULL: const_null_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         in_value_ff <= req_if.value;
         in_null_ff <= req_if.is_null;
         in_start_ff <= req_if.zone_start;
      end
   end

   // Fold the item into the zone, clearing first on zone start
   always_comb begin
      base_env = in_start_ff ? 1'b0 : have_env_ff;
      base_min = in_start_ff ? '0 : min_ff;
      base_max = in_start_ff ? '0 : max_ff;
      base_val = in_start_ff ? '0 : rows_val_ff;
      base_null = in_start_ff ? '0 : rows_null_ff;

      have_env_in = base_env;
      min_in = base_min;
      max_in = base_max;
      rows_val_in = base_val;
      rows_null_in = base_null;

      if (in_null_ff) begin
         rows_null_in = (base_null < zmp_pkg::COUNT_CAP) ? base_null + 1'b1 : zmp_pkg::COUNT_CAP;
      end else begin
         rows_val_in = (base_val < zmp_pkg::COUNT_CAP) ? base_val + 1'b1 : zmp_pkg::COUNT_CAP;
         if (!base_env || (in_value_ff < base_min)) begin
            min_in = in_value_ff;
         end
         if (!base_env || (base_max < in_value_ff)) begin
            max_in = in_value_ff;
         end
         have_env_in = 1'b1;
      end
   end

   // Evaluate the predicate against the updated envelope
   always_comb begin
      case (pred_op_ff)
         zmp_pkg::OP_EQ: op_hit = (min_in <= const_value_ff) && (const_value_ff <= max_in);
         zmp_pkg::OP_NE: op_hit = !((min_in == const_value_ff) && (max_in == const_value_ff));
         zmp_pkg::OP_LT: op_hit = min_in < const_value_ff;
         zmp_pkg::OP_LE: op_hit = min_in <= const_value_ff;
         zmp_pkg::OP_GT: op_hit = const_value_ff < max_in;
         zmp_pkg::OP_GE: op_hit = const_value_ff <= max_in;
         default: op_hit = 1'b1;
      endcase
      // The envelope is in use only after a non-NULL item; an all-NULL zone never matches
      match_in = !const_null_ff && have_env_in && op_hit;
   end

   // Update the zone state
   always_ff @(posedge clock) begin
      if (reset) begin
         have_env_ff <= 1'b0;
         min_ff <= '0;
         max_ff <= '0;
         rows_val_ff <= '0;
         rows_null_ff <= '0;
      end else if (advance) begin
         have_env_ff <= have_env_in;
         min_ff <= min_in;
         max_ff <= max_in;
         rows_val_ff <= rows_val_in;
         rows_null_ff <= rows_null_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         match_ff <= match_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.may_match = match_ff;
   assign rsp_if.zone_min = min_ff;
   assign rsp_if.zone_max = max_ff;
   assign rsp_if.value_count = rows_val_ff;
   assign rsp_if.null_count = rows_null_ff;
   assign rsp_if.has_values = have_env_ff;

`ifndef SYNTH
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after advance");

   a_env_tracks_count: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (have_env_ff == (rows_val_ff != '0)))
      else $error("envelope flag disagrees with non-NULL count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && have_env_ff) |-> (min_ff <= max_ff))
      else $error("zone minimum above maximum");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (rows_val_ff <= zmp_pkg::COUNT_CAP) && (rows_null_ff <= zmp_pkg::COUNT_CAP))
      else $error("row count beyond saturation cap");

   a_null_const_no_match: assert property (@(posedge clock) disable iff (reset)
      (advance && const_null_ff) |=> !match_ff)
      else $error("NULL constant reported a possible match");
`endif

endmodule
